### hw/rtl/mvf_pkg.sv
`default_nettype none
package mvf_pkg;

    // Full scale of the mixing ratio, 100 % in 1/256 %
    localparam logic [14:0] FULL_SCALE = 15'd25600;
    // Smoothed position after reset, 50 % in 1/65536 %
    localparam logic [23:0] POS_RESET = 24'd3276800;

    // Register reset values
    localparam logic [15:0] COUPLING_RESET = 16'd0;
    localparam logic [13:0] FLOOR_MIN_RESET = 14'd51;
    localparam logic [13:0] FLOOR_MAX_RESET = 14'd512;
    localparam logic [21:0] TAU_RESET = 22'd180000;

    // Register indexes
    localparam logic [7:0] REG_COUPLING = 8'd0;
    localparam logic [7:0] REG_FLOOR_MIN = 8'd1;
    localparam logic [7:0] REG_FLOOR_MAX = 8'd2;
    localparam logic [7:0] REG_TAU = 8'd3;

    // Request kinds
    localparam logic REQ_STEP = 1'b0;
    localparam logic REQ_RESEED = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMUL,
        ST_SINIT,
        ST_SQRT,
        ST_CLAMP,
        ST_DECIDE,
        ST_DIV,
        ST_POST1,
        ST_BMUL,
        ST_BINIT,
        ST_POST2,
        ST_FILT,
        ST_FMUL,
        ST_FINIT,
        ST_FAPPLY,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

### hw/rtl/mixing_valve_feedforward.sv
`default_nettype none
// Mixing-valve feedforward with authority floor, demand blend and output filter.
// Input channel s_*: one item per control step or reseed. s_tuser holds
// req_type; s_tdata holds setpoint, return, source and time_ms.
// Result channel m_*: one item per control step, none for a reseed.
// m_tdata holds valve_position and authority_floor; m_tuser holds limited.
// Configuration channel cfg_*: always ready, one register per write; write
// only while the block is idle.
// A control step shows its result in the same cycle that the input reopens.
// The work is done by one shared restoring divide/square-root subtractor (one
// bit per cycle: 16 root bits, only with a nonzero coupling gain, 32 quotient
// bits for the ratio, 16 for the blend, 25 for the filter) and one shared
// registered multiplier, run by a sequencer.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; the next item is accepted while it
// waits. When the receiver stalls, the next finished result waits in the
// sequencer until the output register is free.
// Reset (aresetn low, synchronous) restores register defaults, clears the
// filter and time valid flags and drops any pending result.
module mixing_valve_feedforward (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // temp_setpoint, temp_return, temp_source, time_ms
    input  wire logic [0:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // valve_position, authority_floor, zero pad
    output logic [0:0]       m_tuser,   // limited
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    mvf_pkg::state_t state_reg, state_next, ret_reg, ret_next;

    logic [15:0] coupling_reg, coupling_next;
    logic [13:0] fmin_reg, fmin_next, fmax_reg, fmax_next;
    logic [21:0] tau_reg, tau_next;
    logic [23:0] s_reg, s_next;
    logic        pv_reg, pv_next, tv_reg, tv_next;
    logic [31:0] last_reg, last_next;

    logic signed [16:0] want_reg, want_next, denom_reg, denom_next;
    logic [15:0] awant_reg, awant_next, aden_reg, aden_next;
    logic [31:0] dt_reg, dt_next;
    logic [13:0] flr_reg, flr_next;
    logic        lim_reg, lim_next, up_reg, up_next;
    logic [14:0] raw_reg, raw_next;
    logic [63:0] prod_reg;
    logic [32:0] rem_reg, rem_next, dvs_reg, dvs_next, den_reg, den_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [15:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic        m_valid_reg, m_valid_next;
    logic [14:0] mpos_reg, mpos_next;
    logic [13:0] mflr_reg, mflr_next;
    logic        mlim_reg, mlim_next;

    logic signed [16:0] tset, tret, tsrc, want_in, denom_in;
    logic [31:0] now;
    logic [13:0] lo, hi;
    logic [22:0] awant100;
    logic [31:0] mul_a, mul_b;
    logic [34:0] sub_a, sub_b, sub_d;
    logic        ge;
    logic [33:0] div_sh;
    logic [32:0] sq_sh;
    logic [23:0] target, fdiff;
    logic [56:0] fdvd;
    logic [24:0] round_pos;
    logic        den_pos, want_pos;

    assign s_tready  = (state_reg == mvf_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {3'b000, mflr_reg, mpos_reg};
    assign m_tuser   = mlim_reg;

    // Unpack inputs and derived values
    assign tset     = {s_tdata[15], s_tdata[15:0]};
    assign tret     = {s_tdata[31], s_tdata[31:16]};
    assign tsrc     = {s_tdata[47], s_tdata[47:32]};
    assign now      = s_tdata[79:48];
    assign want_in  = tset - tret;
    assign denom_in = tsrc - tret;
    assign lo       = (fmin_reg == 14'd0) ? 14'd1 : fmin_reg;
    assign hi       = (fmax_reg > lo) ? fmax_reg : lo;
    assign awant100 = ({7'd0, awant_reg} << 6) + ({7'd0, awant_reg} << 5)
                    + ({7'd0, awant_reg} << 2);
    assign target   = {1'b0, raw_reg, 8'd0};
    assign fdiff    = up_reg ? (target - s_reg) : (s_reg - target);
    assign fdvd     = {1'b0, prod_reg[55:0]} + {25'd0, den_reg[32:1]};
    assign want_pos = (want_reg > 17'sd0);
    assign den_pos  = (denom_reg != 17'sd0) ? (denom_reg > 17'sd0) : want_pos;
    assign round_pos = {1'b0, s_reg} + 25'd128;

    // Shared subtractor: root trial in the square-root state, divisor otherwise
    assign div_sh = {rem_reg, dvd_reg[63]};
    assign sq_sh  = {rem_reg[30:0], dvd_reg[63:62]};
    always_comb begin
        if (state_reg == mvf_pkg::ST_SQRT) begin
            sub_a = {2'b00, sq_sh};
            sub_b = {17'd0, root_reg, 2'b01};
        end else begin
            sub_a = {1'b0, div_sh};
            sub_b = {2'b00, dvs_reg};
        end
    end
    assign sub_d = sub_a - sub_b;
    assign ge    = ~sub_d[34];

    // Shared multiplier operands
    always_comb begin
        case (state_reg)
            mvf_pkg::ST_CMUL: begin
                mul_a = {9'd0, awant100};
                mul_b = {16'd0, coupling_reg};
            end
            mvf_pkg::ST_BMUL: begin
                mul_a = {17'd0, raw_reg};
                mul_b = {16'd0, aden_reg};
            end
            mvf_pkg::ST_FMUL: begin
                mul_a = {8'd0, fdiff};
                mul_b = dt_reg;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        coupling_next = coupling_reg;
        fmin_next     = fmin_reg;
        fmax_next     = fmax_reg;
        tau_next      = tau_reg;
        s_next        = s_reg;
        pv_next       = pv_reg;
        tv_next       = tv_reg;
        last_next     = last_reg;
        want_next     = want_reg;
        denom_next    = denom_reg;
        awant_next    = awant_reg;
        aden_next     = aden_reg;
        dt_next       = dt_reg;
        flr_next      = flr_reg;
        lim_next      = lim_reg;
        up_next       = up_reg;
        raw_next      = raw_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        dvs_next      = dvs_reg;
        den_next      = den_reg;
        root_next     = root_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        mpos_next     = mpos_reg;
        mflr_next     = mflr_reg;
        mlim_next     = mlim_reg;

        // Configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                mvf_pkg::REG_COUPLING:  coupling_next = cfg_data[15:0];
                mvf_pkg::REG_FLOOR_MIN: fmin_next = cfg_data[13:0];
                mvf_pkg::REG_FLOOR_MAX: fmax_next = cfg_data[13:0];
                mvf_pkg::REG_TAU:       tau_next = cfg_data[21:0];
                default: ;
            endcase
        end

        // Drop a result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            mvf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == mvf_pkg::REQ_RESEED) begin
                        pv_next = 1'b0;
                    end else begin
                        want_next  = want_in;
                        denom_next = denom_in;
                        awant_next = want_in[16] ? 16'(-want_in) : want_in[15:0];
                        aden_next  = denom_in[16] ? 16'(-denom_in) : denom_in[15:0];
                        dt_next    = tv_reg ? (now - last_reg) : 32'd0;
                        last_next  = now;
                        tv_next    = 1'b1;
                        flr_next   = lo;
                        state_next = (coupling_reg != 16'd0) ? mvf_pkg::ST_CMUL
                                                             : mvf_pkg::ST_DECIDE;
                    end
                end
            end
            mvf_pkg::ST_CMUL: begin
                state_next = mvf_pkg::ST_SINIT;
            end
            mvf_pkg::ST_SINIT: begin
                dvd_next   = {1'b0, prod_reg[38:8], 32'd0};
                rem_next   = 33'd0;
                root_next  = 16'd0;
                cnt_next   = 6'd16;
                state_next = mvf_pkg::ST_SQRT;
            end
            mvf_pkg::ST_SQRT: begin
                // One root bit per cycle, two radicand bits shifted in
                dvd_next = {dvd_reg[61:0], 2'b00};
                if (ge) begin
                    rem_next  = sub_d[32:0];
                    root_next = {root_reg[14:0], 1'b1};
                end else begin
                    rem_next  = sq_sh;
                    root_next = {root_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = mvf_pkg::ST_CLAMP;
                end
            end
            mvf_pkg::ST_CLAMP: begin
                if (root_reg < {2'b00, lo}) begin
                    flr_next = lo;
                end else if (root_reg > {2'b00, hi}) begin
                    flr_next = hi;
                end else begin
                    flr_next = root_reg[13:0];
                end
                state_next = mvf_pkg::ST_DECIDE;
            end
            mvf_pkg::ST_DECIDE: begin
                lim_next = (aden_reg < {2'b00, flr_reg});
                rem_next = 33'd0;
                dvd_next = {1'b0, awant100, 8'd0, 32'd0};
                cnt_next = 6'd32;
                ret_next = mvf_pkg::ST_POST1;
                if (aden_reg >= {2'b00, flr_reg}) begin
                    // Full authority: plain ratio when signs agree
                    dvs_next = {17'd0, aden_reg};
                    if ((want_reg > 17'sd0 && denom_reg > 17'sd0) ||
                        (want_reg < 17'sd0 && denom_reg < 17'sd0)) begin
                        state_next = mvf_pkg::ST_DIV;
                    end else begin
                        raw_next   = 15'd0;
                        state_next = mvf_pkg::ST_FILT;
                    end
                end else begin
                    // Below the floor: demand against the floor
                    dvs_next = {19'd0, flr_reg};
                    if (want_reg != 17'sd0) begin
                        state_next = mvf_pkg::ST_DIV;
                    end else begin
                        raw_next   = 15'd0;
                        state_next = mvf_pkg::ST_FILT;
                    end
                end
            end
            mvf_pkg::ST_DIV: begin
                // Restoring division, one quotient bit per cycle
                if (ge) begin
                    rem_next = sub_d[32:0];
                    dvd_next = {dvd_reg[62:0], 1'b1};
                end else begin
                    rem_next = div_sh[32:0];
                    dvd_next = {dvd_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = ret_reg;
                end
            end
            mvf_pkg::ST_POST1: begin
                raw_next = (dvd_reg[31:0] > {17'd0, mvf_pkg::FULL_SCALE})
                         ? mvf_pkg::FULL_SCALE : dvd_reg[14:0];
                if (lim_reg && (den_pos != want_pos)) begin
                    state_next = mvf_pkg::ST_BMUL;
                end else begin
                    state_next = mvf_pkg::ST_FILT;
                end
            end
            mvf_pkg::ST_BMUL: begin
                state_next = mvf_pkg::ST_BINIT;
            end
            mvf_pkg::ST_BINIT: begin
                rem_next   = {21'd0, prod_reg[27:16]};
                dvd_next   = {prod_reg[15:0], 48'd0};
                dvs_next   = {19'd0, flr_reg};
                cnt_next   = 6'd16;
                ret_next   = mvf_pkg::ST_POST2;
                state_next = mvf_pkg::ST_DIV;
            end
            mvf_pkg::ST_POST2: begin
                raw_next   = raw_reg - dvd_reg[14:0];
                state_next = mvf_pkg::ST_FILT;
            end
            mvf_pkg::ST_FILT: begin
                up_next = (target >= s_reg);
                if (tau_reg != 22'd0 && pv_reg && dt_reg != 32'd0) begin
                    state_next = mvf_pkg::ST_FMUL;
                end else begin
                    s_next     = target;
                    state_next = mvf_pkg::ST_DONE;
                end
            end
            mvf_pkg::ST_FMUL: begin
                den_next   = {11'd0, tau_reg} + {1'b0, dt_reg};
                state_next = mvf_pkg::ST_FINIT;
            end
            mvf_pkg::ST_FINIT: begin
                // Add half the divisor for round to nearest
                rem_next   = {1'b0, fdvd[56:25]};
                dvd_next   = {fdvd[24:0], 39'd0};
                dvs_next   = den_reg;
                cnt_next   = 6'd25;
                ret_next   = mvf_pkg::ST_FAPPLY;
                state_next = mvf_pkg::ST_DIV;
            end
            mvf_pkg::ST_FAPPLY: begin
                s_next = up_reg ? (s_reg + dvd_reg[23:0]) : (s_reg - dvd_reg[23:0]);
                state_next = mvf_pkg::ST_DONE;
            end
            mvf_pkg::ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    mpos_next    = round_pos[22:8];
                    mflr_next    = flr_reg;
                    mlim_next    = lim_reg;
                    pv_next      = 1'b1;
                    state_next   = mvf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mvf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mvf_pkg::ST_IDLE;
            coupling_reg <= mvf_pkg::COUPLING_RESET;
            fmin_reg     <= mvf_pkg::FLOOR_MIN_RESET;
            fmax_reg     <= mvf_pkg::FLOOR_MAX_RESET;
            tau_reg      <= mvf_pkg::TAU_RESET;
            s_reg        <= mvf_pkg::POS_RESET;
            pv_reg       <= 1'b0;
            tv_reg       <= 1'b0;
            last_reg     <= 32'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            coupling_reg <= coupling_next;
            fmin_reg     <= fmin_next;
            fmax_reg     <= fmax_next;
            tau_reg      <= tau_next;
            s_reg        <= s_next;
            pv_reg       <= pv_next;
            tv_reg       <= tv_next;
            last_reg     <= last_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        ret_reg   <= ret_next;
        want_reg  <= want_next;
        denom_reg <= denom_next;
        awant_reg <= awant_next;
        aden_reg  <= aden_next;
        dt_reg    <= dt_next;
        flr_reg   <= flr_next;
        lim_reg   <= lim_next;
        up_reg    <= up_next;
        raw_reg   <= raw_next;
        prod_reg  <= mul_a * mul_b;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        dvs_reg   <= dvs_next;
        den_reg   <= den_next;
        root_reg  <= root_next;
        cnt_reg   <= cnt_next;
        mpos_reg  <= mpos_next;
        mflr_reg  <= mflr_next;
        mlim_reg  <= mlim_next;
    end

endmodule
`default_nettype wire

### hw/rtl/mvf_checker.sv
`default_nettype none
module mvf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Position never exceeds full scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[14:0] <= mvf_pkg::FULL_SCALE)
        else $error("valve position out of range");

    // Floor is never zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[28:15] != 14'd0)
        else $error("zero authority floor");

    // A control step keeps the input closed next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == mvf_pkg::REQ_STEP |=> !s_tready)
        else $error("input reopened during a step");

    // Reset drops a pending result
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind mixing_valve_feedforward mvf_checker u_mvf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### tb/sv/mixing_valve_feedforward_checker.sv
`default_nettype none
module mixing_valve_feedforward_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [79:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [0:0]  m_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [14:0] position;
        logic        limited;
        logic [13:0] floor_used;
    } valve_result_t;

    valve_result_t valve_queue[$];

    // shadow registers and filter state
    logic [15:0] gain_q;
    logic [13:0] fmin_q, fmax_q;
    logic [21:0] tau_q;
    logic [31:0] smooth_q, tick_q;
    logic        smooth_ok, tick_ok;

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] scaled_ratio(input logic [31:0] num, input logic [31:0] den);
        logic [63:0] q;
        q = (64'(num) * 64'(mvf_pkg::FULL_SCALE)) / 64'(den);
        return (q > 64'(mvf_pkg::FULL_SCALE)) ? 32'(mvf_pkg::FULL_SCALE) : q[31:0];
    endfunction

    // evaluate one control step and advance the filter
    task automatic predict_step(input logic [79:0] d);
        int          tset, tret, tsrc, want, denom;
        logic [31:0] now, dt, lo, hi, flr, awant, aden, raw, demand, target;
        logic [63:0] root, den, m;
        logic        lim, wpos, dpos;
        valve_result_t r;
        tset = int'($signed(d[15:0]));
        tret = int'($signed(d[31:16]));
        tsrc = int'($signed(d[47:32]));
        now = d[79:48];
        dt = tick_ok ? now - tick_q : 32'd0;
        tick_q = now;
        tick_ok = 1'b1;
        lo = (fmin_q != 0) ? 32'(fmin_q) : 32'd1;
        hi = (32'(fmax_q) > lo) ? 32'(fmax_q) : lo;
        flr = lo;
        want = tset - tret;
        denom = tsrc - tret;
        awant = (want < 0) ? -want : want;
        aden = (denom < 0) ? -denom : denom;
        if (gain_q != 0) begin
            root = root64((64'(awant) * 64'd100 * 64'(gain_q)) >> 8);
            flr = (root < 64'(lo)) ? lo : ((root > 64'(hi)) ? hi : root[31:0]);
        end
        lim = aden < flr;
        if (!lim) begin
            raw = ((want > 0 && denom > 0) || (want < 0 && denom < 0))
                  ? scaled_ratio(awant, aden) : 32'd0;
        end else begin
            wpos = want > 0;
            dpos = (denom != 0) ? (denom > 0) : wpos;
            demand = (want != 0) ? scaled_ratio(awant, flr) : 32'd0;
            raw = (dpos == wpos) ? demand
                  : demand - 32'((64'(demand) * 64'(aden)) / 64'(flr));
        end
        target = raw << 8;
        if (tau_q != 0 && smooth_ok && dt != 0) begin
            den = 64'(tau_q) + 64'(dt);
            if (target >= smooth_q) begin
                m = (64'(target - smooth_q) * 64'(dt) + den / 2) / den;
                smooth_q = smooth_q + m[31:0];
            end else begin
                m = (64'(smooth_q - target) * 64'(dt) + den / 2) / den;
                smooth_q = smooth_q - m[31:0];
            end
        end else begin
            smooth_q = target;
        end
        smooth_q = smooth_q & 32'hFFFFFF;
        smooth_ok = 1'b1;
        r.position = 15'((smooth_q + 32'd128) >> 8);
        r.limited = lim;
        r.floor_used = flr[13:0];
        valve_queue.push_back(r);
    endtask

    always @(posedge aclk) begin
        valve_result_t e;
        if (!aresetn) begin
            gain_q <= mvf_pkg::COUPLING_RESET;
            fmin_q <= mvf_pkg::FLOOR_MIN_RESET;
            fmax_q <= mvf_pkg::FLOOR_MAX_RESET;
            tau_q <= mvf_pkg::TAU_RESET;
            smooth_q = 32'(mvf_pkg::POS_RESET);
            smooth_ok = 1'b0;
            tick_q = 0;
            tick_ok = 1'b0;
            valve_queue.delete();
            fail_count <= 0;
        end else begin
            // track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mvf_pkg::REG_COUPLING:  gain_q <= cfg_data[15:0];
                    mvf_pkg::REG_FLOOR_MIN: fmin_q <= cfg_data[13:0];
                    mvf_pkg::REG_FLOOR_MAX: fmax_q <= cfg_data[13:0];
                    mvf_pkg::REG_TAU:       tau_q <= cfg_data[21:0];
                    default: ;
                endcase
            end
            // predict accepted items
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == mvf_pkg::REQ_RESEED) smooth_ok = 1'b0;
                else predict_step(s_tdata);
            end
            // compare results against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (valve_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: pos=%0d lim=%0d floor=%0d",
                                 m_tdata[14:0], m_tuser[0], m_tdata[28:15]);
                    fail_count <= fail_count + 1;
                end else begin
                    e = valve_queue.pop_front();
                    if (m_tdata[14:0] !== e.position || m_tuser[0] !== e.limited ||
                        m_tdata[28:15] !== e.floor_used) begin
                        if (fail_count < 10)
                            $display("mismatch: exp pos=%0d lim=%0d floor=%0d, got %0d %0d %0d",
                                     e.position, e.limited, e.floor_used,
                                     m_tdata[14:0], m_tuser[0], m_tdata[28:15]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count <= valve_queue.size();
    end
endmodule
`default_nettype wire

### tb/sv/mixing_valve_feedforward_tb.sv
`default_nettype none
module mixing_valve_feedforward_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count, pending_count;
    int          idle_cycles = 0;
    logic        hold_sink = 1'b0;
    logic [31:0] tick = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mixing_valve_feedforward DUT (.*);
    mixing_valve_feedforward_checker u_checker (.*);

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // receiver: random stalls, plus a long hold on request
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_sink = 1'b0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            m_tready <= (g == 0);
            @(posedge aclk);
            if (g > 1) repeat (g - 1) @(posedge aclk);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic kind, input logic [15:0] set_t,
                             input logic [15:0] ret_t, input logic [15:0] src_t,
                             input logic [31:0] ms);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {ms, src_t, ret_t, set_t};
        @(posedge aclk iff s_tready);
    endtask

    task automatic step_gap();
        int g;
        g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // let the count include the last accepted item before waiting for it to drain
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    // random temperatures: mostly realistic, sometimes full range
    function automatic logic [15:0] rand_temp(input logic [15:0] near);
        int p;
        p = $urandom_range(0, 9);
        if (p < 6) return near + 16'($urandom_range(0, 2048)) - 16'd1024;
        if (p < 8) return near + 16'($urandom_range(0, 64)) - 16'd32;
        return 16'($urandom);
    endfunction

    task automatic random_phase(input int n);
        logic [15:0] ret_t;
        for (int i = 0; i < n; i++) begin
            ret_t = 16'($urandom_range(0, 20000));
            if ($urandom_range(0, 19) == 0) begin
                send_item(mvf_pkg::REQ_RESEED, 16'($urandom), 16'($urandom),
                          16'($urandom), $urandom);
            end else begin
                tick = ($urandom_range(0, 9) == 0) ? $urandom
                       : tick + 32'($urandom_range(0, 3000));
                send_item(mvf_pkg::REQ_STEP, rand_temp(ret_t), ret_t, rand_temp(ret_t), tick);
            end
            step_gap();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes and special cases at reset settings
        send_item(mvf_pkg::REQ_STEP, 16'h7FFF, 16'h8000, 16'h7FFF, 32'd0);
        send_item(mvf_pkg::REQ_STEP, 16'h8000, 16'h7FFF, 16'h8000, 32'd0);
        send_item(mvf_pkg::REQ_STEP, 16'd100, 16'd100, 16'd100, 32'd5);
        send_item(mvf_pkg::REQ_STEP, 16'd200, 16'd100, 16'd100, 32'd10);
        send_item(mvf_pkg::REQ_STEP, 16'd50, 16'd100, 16'd100, 32'd20);
        send_item(mvf_pkg::REQ_STEP, 16'd300, 16'd100, 16'd90, 32'd4000);
        send_item(mvf_pkg::REQ_STEP, 16'd90, 16'd100, 16'd130, 32'hFFFF_FFFF);
        send_item(mvf_pkg::REQ_RESEED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(mvf_pkg::REQ_STEP, 16'd5000, 16'd1000, 16'd9000, 32'd100);
        send_item(mvf_pkg::REQ_STEP, 16'd1000, 16'd5000, 16'd0, 32'd90000);
        drain();

        // strong coupling, zero floor_min, floor_max below min, no filtering
        write_reg(mvf_pkg::REG_COUPLING, 32'hFFFF);
        write_reg(mvf_pkg::REG_FLOOR_MIN, 32'd0);
        write_reg(mvf_pkg::REG_FLOOR_MAX, 32'd0);
        write_reg(mvf_pkg::REG_TAU, 32'd0);
        write_reg(8'd7, 32'hFFFF_FFFF);
        send_item(mvf_pkg::REQ_STEP, 16'h7FFF, 16'h8000, 16'h8001, 32'd1);
        send_item(mvf_pkg::REQ_STEP, 16'd120, 16'd100, 16'd101, 32'd2);
        send_item(mvf_pkg::REQ_STEP, 16'd80, 16'd100, 16'd100, 32'd3);
        drain();
        write_reg(mvf_pkg::REG_FLOOR_MIN, 32'd8192);
        write_reg(mvf_pkg::REG_FLOOR_MAX, 32'd8192);
        write_reg(mvf_pkg::REG_TAU, 32'h3F_FFFF);
        send_item(mvf_pkg::REQ_STEP, 16'd3000, 16'd100, 16'd2000, 32'd50);
        send_item(mvf_pkg::REQ_STEP, 16'd3000, 16'd100, 16'd50, 32'd70000);
        send_item(mvf_pkg::REQ_STEP, 16'd100, 16'd100, 16'd50, 32'd80000);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(mvf_pkg::REG_COUPLING,
                      (ph == 0) ? 32'd0 : 32'($urandom_range(0, 65535)));
            write_reg(mvf_pkg::REG_FLOOR_MIN, 32'($urandom_range(1, (ph < 3) ? 300 : 8192)));
            write_reg(mvf_pkg::REG_FLOOR_MAX, 32'($urandom_range(1, (ph < 3) ? 2000 : 8192)));
            write_reg(mvf_pkg::REG_TAU, (ph == 1) ? 32'd0 : 32'($urandom_range(1, 20000)));
            if (ph == 2) begin
                // long receiver hold while items keep coming
                hold_sink = 1'b1;
            end
            random_phase(270);
            drain();
        end

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
